### sv/fdho_pkg.sv
`default_nettype none

package fdho_pkg;

  localparam int PIX_W      = 8;
  localparam int SUM_W      = 10;
  localparam int CNT_W      = 19;
  localparam int SIZE_W     = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 19;
  localparam int IN_TDATA_W  = 6 * PIX_W;
  localparam int OUT_TDATA_W = 8;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [SUM_W-1:0]  DIFF_THR_RESET  = SUM_W'(60);
  localparam logic [CNT_W-1:0]  COUNT_THR_RESET = CNT_W'(1500);
  localparam logic [SIZE_W-1:0] WIDTH_RESET     = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET    = SIZE_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIFF_THR  = 2'd0,
    CFG_COUNT_THR = 2'd1,
    CFG_WIDTH     = 2'd2,
    CFG_HEIGHT    = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    HAND_NONE  = 2'd0,
    HAND_LEFT  = 2'd1,
    HAND_RIGHT = 2'd2,
    HAND_BOTH  = 2'd3
  } hand_t;

  // The first member sits in the highest bits, so ref_red lands in bits 7:0.
  typedef struct packed {
    logic [PIX_W-1:0] live_blue;
    logic [PIX_W-1:0] live_green;
    logic [PIX_W-1:0] live_red;
    logic [PIX_W-1:0] ref_blue;
    logic [PIX_W-1:0] ref_green;
    logic [PIX_W-1:0] ref_red;
  } pixel_t;

  typedef struct packed {
    logic [SUM_W-1:0]  diff_threshold;
    logic [CNT_W-1:0]  count_threshold;
    logic [SIZE_W-1:0] frame_width;
    logic [SIZE_W-1:0] frame_height;
  } cfg_t;

  typedef struct packed {
    logic  frame_done;
    hand_t hand_state;
  } trk_res_t;

endpackage

`default_nettype wire

### sv/fdho_sad.sv
`default_nettype none

module fdho_sad (
  input  fdho_pkg::pixel_t              pixel,
  input  logic [fdho_pkg::SUM_W-1:0]    diff_threshold,
  output logic                          foreground
);

  logic [fdho_pkg::PIX_W-1:0] diff_r;
  logic [fdho_pkg::PIX_W-1:0] diff_g;
  logic [fdho_pkg::PIX_W-1:0] diff_b;
  logic [fdho_pkg::SUM_W-1:0] sum;

  always_comb begin
    diff_r = (pixel.ref_red >= pixel.live_red) ? pixel.ref_red - pixel.live_red
                                               : pixel.live_red - pixel.ref_red;
    diff_g = (pixel.ref_green >= pixel.live_green) ? pixel.ref_green - pixel.live_green
                                                   : pixel.live_green - pixel.ref_green;
    diff_b = (pixel.ref_blue >= pixel.live_blue) ? pixel.ref_blue - pixel.live_blue
                                                 : pixel.live_blue - pixel.ref_blue;
    sum = fdho_pkg::SUM_W'(diff_r) + fdho_pkg::SUM_W'(diff_g) + fdho_pkg::SUM_W'(diff_b);
    foreground = (sum >= diff_threshold);
  end

endmodule

`default_nettype wire

### sv/fdho_tracker.sv
`default_nettype none

module fdho_tracker #(
  parameter int MAX_WIDTH  = fdho_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdho_pkg::DEF_MAX_HEIGHT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                foreground,
  input  fdho_pkg::cfg_t      cfg,
  output fdho_pkg::trk_res_t  res
);

  localparam int ColW = $clog2(MAX_WIDTH);
  localparam int RowW = $clog2(MAX_HEIGHT);
  localparam int WExt = $clog2(MAX_WIDTH + 1);
  localparam int HExt = $clog2(MAX_HEIGHT + 1);
  localparam int SzWW = (WExt > fdho_pkg::SIZE_W) ? WExt : fdho_pkg::SIZE_W;
  localparam int SzHW = (HExt > fdho_pkg::SIZE_W) ? HExt : fdho_pkg::SIZE_W;

  logic [ColW-1:0]            column_pos;
  logic [ColW-1:0]            column_pos_next;
  logic [RowW-1:0]            row_pos;
  logic [RowW-1:0]            row_pos_next;
  logic [fdho_pkg::CNT_W-1:0] left_count;
  logic [fdho_pkg::CNT_W-1:0] left_count_next;
  logic [fdho_pkg::CNT_W-1:0] right_count;
  logic [fdho_pkg::CNT_W-1:0] right_count_next;

  logic [SzWW-1:0] fw_ext;
  logic [SzWW-1:0] w;
  logic [SzWW-1:0] half_w;
  logic [SzWW-1:0] col_ext;
  logic [SzHW-1:0] fh_ext;
  logic [SzHW-1:0] h;
  logic [SzHW-1:0] row_ext;
  logic            row_end;
  logic            done;
  logic            lower;
  logic            in_left;
  logic            in_right;
  logic            left_hit;
  logic            right_hit;

  always_comb begin
    fw_ext = SzWW'(cfg.frame_width);
    fh_ext = SzHW'(cfg.frame_height);
    if (fw_ext < SzWW'(2)) begin
      w = SzWW'(2);
    end else if (fw_ext > SzWW'(MAX_WIDTH)) begin
      w = SzWW'(MAX_WIDTH);
    end else begin
      w = fw_ext;
    end
    if (fh_ext < SzHW'(2)) begin
      h = SzHW'(2);
    end else if (fh_ext > SzHW'(MAX_HEIGHT)) begin
      h = SzHW'(MAX_HEIGHT);
    end else begin
      h = fh_ext;
    end

    half_w  = w >> 1;
    col_ext = SzWW'(column_pos);
    row_ext = SzHW'(row_pos);
    row_end = (col_ext >= w - SzWW'(1));
    done    = row_end && (row_ext >= h - SzHW'(1));
    lower   = (row_ext >= (h >> 1));
    in_left  = (col_ext < half_w);
    in_right = !in_left && (col_ext < (half_w << 1));

    left_count_next  = left_count;
    right_count_next = right_count;
    if (foreground && lower && in_left && !(&left_count)) begin
      left_count_next = left_count + fdho_pkg::CNT_W'(1);
    end
    if (foreground && lower && in_right && !(&right_count)) begin
      right_count_next = right_count + fdho_pkg::CNT_W'(1);
    end

    left_hit  = (left_count_next > cfg.count_threshold);
    right_hit = (right_count_next > cfg.count_threshold);

    res.frame_done = done;
    res.hand_state = fdho_pkg::HAND_NONE;
    if (done) begin
      unique case ({right_hit, left_hit})
        2'b00:   res.hand_state = fdho_pkg::HAND_NONE;
        2'b01:   res.hand_state = fdho_pkg::HAND_LEFT;
        2'b10:   res.hand_state = fdho_pkg::HAND_RIGHT;
        default: res.hand_state = fdho_pkg::HAND_BOTH;
      endcase
    end

    if (done) begin
      column_pos_next = '0;
      row_pos_next    = '0;
    end else if (row_end) begin
      column_pos_next = '0;
      row_pos_next    = row_pos + RowW'(1);
    end else begin
      column_pos_next = column_pos + ColW'(1);
      row_pos_next    = row_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos  <= '0;
      row_pos     <= '0;
      left_count  <= '0;
      right_count <= '0;
    end else if (step) begin
      column_pos <= column_pos_next;
      row_pos    <= row_pos_next;
      if (done) begin
        left_count  <= '0;
        right_count <= '0;
      end else begin
        left_count  <= left_count_next;
        right_count <= right_count_next;
      end
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (rst)
    step && done |=> column_pos == '0 && row_pos == '0 && left_count == '0
                     && right_count == '0)
    else $error("Frame end did not clear position and counts.");

  assert property (@(posedge clk) disable iff (rst)
    step && !done |=> left_count >= $past(left_count) && right_count >= $past(right_count))
    else $error("A foreground count fell inside a frame.");

  assert property (@(posedge clk) disable iff (rst)
    res.hand_state != fdho_pkg::HAND_NONE |-> done)
    else $error("Hand state reported away from the last pixel.");

  assert property (@(posedge clk) disable iff (rst)
    step && !row_end |=> row_pos == $past(row_pos))
    else $error("Row advanced in the middle of a row.");
`endif

endmodule

`default_nettype wire

### sv/frame_diff_hand_occupancy_core.sv
// Frame-difference hand occupancy core.
// Input stream s_*: one pixel per item in raster order, reference RGB and live RGB.
// Output stream m_*: one item per pixel with the foreground bit; m_tlast marks the
// last pixel of a frame, and on that item the hand state (none, left, right, both)
// is valid, else it reads as none. Row and column are counted inside the block.
// Configuration channel cfg_*: index 0 difference threshold, 1 count threshold,
// 2 frame width, 3 frame height; always ready. The user must write it only while
// the stream is idle; the block itself does not enforce this. Output valid rises
// once an accepted input item has passed an input register, then the difference,
// region and counter logic into the output register. Throughput is one item per
// cycle while results are taken; both registers advance whenever the output
// register is empty or being taken, so a stalled receiver holds one result and
// one pending pixel and backs up s_tready without losing items.
// Reset (rst, synchronous) empties both stages, sets the registers to 60, 1500,
// 640 and 480, and starts a new frame at row 0, column 0 with cleared counts.
`default_nettype none

module frame_diff_hand_occupancy_core #(
  parameter int MAX_WIDTH  = fdho_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = fdho_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // ref_red, ref_green, ref_blue, live_red, live_green, live_blue
  input  logic [fdho_pkg::IN_TDATA_W-1:0]       s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // foreground, hand_state, zero padding
  output logic [fdho_pkg::OUT_TDATA_W-1:0]      m_tdata,
  output logic                                  m_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [fdho_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fdho_pkg::CFG_DATA_W-1:0]       cfg_data
);

  fdho_pkg::cfg_t     cfg;
  fdho_pkg::pixel_t   pix;
  fdho_pkg::trk_res_t res;
  logic               pix_valid;
  logic               advance;
  logic               step;
  logic               foreground;

  assign cfg_ready = 1'b1;
  assign advance   = !m_tvalid || m_tready;
  assign s_tready  = !pix_valid || advance;
  assign step      = pix_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold  <= fdho_pkg::DIFF_THR_RESET;
      cfg.count_threshold <= fdho_pkg::COUNT_THR_RESET;
      cfg.frame_width     <= fdho_pkg::WIDTH_RESET;
      cfg.frame_height    <= fdho_pkg::HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (fdho_pkg::cfg_idx_t'(cfg_index))
        fdho_pkg::CFG_DIFF_THR:  cfg.diff_threshold  <= cfg_data[fdho_pkg::SUM_W-1:0];
        fdho_pkg::CFG_COUNT_THR: cfg.count_threshold <= cfg_data[fdho_pkg::CNT_W-1:0];
        fdho_pkg::CFG_WIDTH:     cfg.frame_width     <= cfg_data[fdho_pkg::SIZE_W-1:0];
        fdho_pkg::CFG_HEIGHT:    cfg.frame_height    <= cfg_data[fdho_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_valid <= 1'b0;
    end else if (s_tready) begin
      pix_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      pix <= fdho_pkg::pixel_t'(s_tdata);
    end
  end

  fdho_sad u_sad (
    .pixel          (pix),
    .diff_threshold (cfg.diff_threshold),
    .foreground     (foreground)
  );

  fdho_tracker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_tracker (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .foreground (foreground),
    .cfg        (cfg),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      m_tdata <= {{(fdho_pkg::OUT_TDATA_W - 3){1'b0}}, res.hand_state, foreground};
      m_tlast <= res.frame_done;
    end
  end

endmodule

`default_nettype wire
